[hdl/bbc_pkg.sv]
// Package with the shared types, constants and sizes of the bracket balance checker.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	// Bracket stack size and the widths that follow from it.
	localparam int STACK_DEPTH = 128;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Character codes of the six brackets.
	localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
	localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

	// Bracket kinds as stored on the stack.
	typedef enum logic [1:0] {
		KIND_PAREN  = 2'd0,
		KIND_BRACE  = 2'd1,
		KIND_SQUARE = 2'd2
	} kind_t;

	// Operation that one character asks of the stack.
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} op_t;

	// Verdict status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_MISMATCH = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_UNCLOSED = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// Classified character as it travels through the queue.
	typedef struct packed {
		op_t   op;
		kind_t kind;
		logic  last;
	} item_t;

endpackage

`default_nettype wire

[hdl/bbc_if.sv]
// Channel interfaces for the character stream and the verdict stream.
`timescale 1ns / 1ps
`default_nettype none

interface bbc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bbc_verdict_if;
	logic       valid;
	logic       ready;
	logic       balanced;
	logic [2:0] status;

	modport source (output valid, output balanced, output status, input ready);
	modport sink   (input valid, input balanced, input status, output ready);
endinterface

`default_nettype wire

[hdl/bbc_front.sv]
// Front stage: accepts characters and classifies them into stack operations.
`timescale 1ns / 1ps
`default_nettype none

module bbc_front
	import bbc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	bbc_char_if.sink   chars,
	output item_t      push_item,
	output logic       push_valid,
	input  wire logic  push_ready
);

	logic  valid_s1;
	item_t item_s1;
	item_t class_item;

	// Map the character byte to an operation and a bracket kind.
	always_comb begin
		class_item.op   = OP_NONE;
		class_item.kind = KIND_PAREN;
		class_item.last = chars.last;
		case (chars.ch)
			CH_OPEN_PAREN: begin
				class_item.op   = OP_OPEN;
				class_item.kind = KIND_PAREN;
			end
			CH_OPEN_BRACE: begin
				class_item.op   = OP_OPEN;
				class_item.kind = KIND_BRACE;
			end
			CH_OPEN_SQUARE: begin
				class_item.op   = OP_OPEN;
				class_item.kind = KIND_SQUARE;
			end
			CH_CLOSE_PAREN: begin
				class_item.op   = OP_CLOSE;
				class_item.kind = KIND_PAREN;
			end
			CH_CLOSE_BRACE: begin
				class_item.op   = OP_CLOSE;
				class_item.kind = KIND_BRACE;
			end
			CH_CLOSE_SQUARE: begin
				class_item.op   = OP_CLOSE;
				class_item.kind = KIND_SQUARE;
			end
			default: begin
				class_item.op   = OP_NONE;
				class_item.kind = KIND_PAREN;
			end
		endcase
	end

	// The stage register frees up whenever the queue takes its content.
	assign chars.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Payload register, loaded on each accepted transaction.
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1 <= class_item;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

`default_nettype wire

[hdl/bbc_queue.sv]
// Short queue that decouples the front stage from the stack engine.
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue
	import bbc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire item_t  push_item,
	input  wire logic   push_valid,
	output logic        push_ready,
	output item_t       pop_item,
	output logic        pop_valid,
	input  wire logic   pop_ready
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

[hdl/bbc_back.sv]
// Stack engine: carries out pushes and pops, tracks failure and delivers verdicts.
`timescale 1ns / 1ps
`default_nettype none

module bbc_back
	import bbc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire item_t  pop_item,
	input  wire logic   pop_valid,
	output logic        pop_ready,
	bbc_verdict_if.source verdict
);

	// Top of stack lives in a register; the entries below it live in the memory.
	kind_t              top_q;
	logic [DEPTH_W-1:0] depth_q;
	status_t            fail_q;
	kind_t              stack_mem [STACK_DEPTH];
	kind_t              mem_rd_q;
	logic               fwd_q;
	kind_t              fwd_val_q;
	logic               out_valid_q;
	logic               balanced_q;
	status_t            status_q;

	kind_t              under;
	logic               fire;
	logic [DEPTH_W-1:0] step_depth;
	logic [DEPTH_W-1:0] next_depth;
	logic [DEPTH_W-1:0] rd_depth;
	logic [DEPTH_W-1:0] wr_depth;
	status_t            step_fail;
	status_t            next_fail;
	status_t            final_status;
	kind_t              next_top;
	logic               do_push;
	logic               wr_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;

	// The entry under the top: freshly pushed-down value or the registered read.
	assign under = fwd_q ? fwd_val_q : mem_rd_q;

	// A last item waits while an earlier verdict is still held.
	assign pop_ready = !pop_item.last || !out_valid_q || verdict.ready;
	assign fire      = pop_valid && pop_ready;

	// One stack operation per transaction until a failure is recorded, then the end-of-string verdict.
	always_comb begin
		step_depth   = depth_q;
		step_fail    = fail_q;
		next_top     = top_q;
		do_push      = 1'b0;
		wr_en        = 1'b0;
		if (fire && (fail_q == ST_OK)) begin
			case (pop_item.op)
				OP_OPEN: begin
					if (depth_q >= DEPTH_W'(STACK_DEPTH)) begin
						step_fail = ST_OVERFLOW;
					end else begin
						do_push    = 1'b1;
						wr_en      = (depth_q != '0);
						step_depth = depth_q + 1'b1;
						next_top   = pop_item.kind;
					end
				end
				OP_CLOSE: begin
					if (depth_q == '0) begin
						step_fail = ST_EMPTY;
					end else begin
						step_depth = depth_q - 1'b1;
						next_top   = under;
						if (top_q != pop_item.kind) begin
							step_fail = ST_MISMATCH;
						end
					end
				end
				default: begin
					step_depth = depth_q;
				end
			endcase
		end

		if (step_fail != ST_OK) begin
			final_status = step_fail;
		end else if (step_depth != '0) begin
			final_status = ST_UNCLOSED;
		end else begin
			final_status = ST_OK;
		end

		if (fire && pop_item.last) begin
			next_depth = '0;
			next_fail  = ST_OK;
		end else begin
			next_depth = step_depth;
			next_fail  = step_fail;
		end
	end

	// Memory addresses: write the old top at depth-1, prefetch the entry at the next depth-2.
	assign wr_depth = depth_q - 1'b1;
	assign rd_depth = next_depth - DEPTH_W'(2);
	assign wr_addr  = wr_depth[ADDR_W-1:0];
	assign rd_addr  = rd_depth[ADDR_W-1:0];

	// Stack control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			fail_q  <= ST_OK;
			fwd_q   <= 1'b0;
		end else begin
			depth_q <= next_depth;
			fail_q  <= next_fail;
			fwd_q   <= do_push;
		end
	end

	// Top register and forwarding value.
	always_ff @(posedge clk) begin
		top_q     <= next_top;
		fwd_val_q <= top_q;
	end

	// Stack memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= top_q;
		end
		mem_rd_q <= stack_mem[rd_addr];
	end

	// Verdict output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && pop_item.last) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pop_item.last) begin
			status_q   <= final_status;
			balanced_q <= (final_status == ST_OK);
		end
	end

	assign verdict.valid    = out_valid_q;
	assign verdict.balanced = balanced_q;
	assign verdict.status   = status_q;

endmodule

`default_nettype wire

[hdl/multi_bracket_balance_checker_unit.sv]
// Top level of the bracket balance checker: front stage, queue and stack engine.
//
//   Channel   Direction  Payload            Transaction
//   chars     sink       ch[7:0], last      one character of the string
//   verdict   source     balanced, status   one verdict per string, on its last character
//
// One character is taken each cycle that chars.ready is high; the stack engine performs
// one push or pop a cycle when not held, against a top-of-stack register and a memory with a
// registered, prefetched read. A last character passes through the front-stage register and
// a queue slot before the stack engine loads its verdict into the verdict register.
// Reset clears the depth, the failure code and all valid state at once; the stack memory
// needs no clearing, since entries are only read below the current depth.
// A stalled verdict holds the engine only when the next item is also a last character;
// the queue and the front stage then fill and lower chars.ready.
`timescale 1ns / 1ps
`default_nettype none

module multi_bracket_balance_checker_unit
	import bbc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	bbc_char_if.sink      chars,
	bbc_verdict_if.source verdict
);

	item_t front_item;
	logic  front_valid;
	logic  front_ready;
	item_t head_item;
	logic  head_valid;
	logic  head_ready;

	// Accept and classify.
	bbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready)
	);

	// Decoupling queue.
	bbc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (front_item),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_item   (head_item),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready)
	);

	// Stack engine and verdict register.
	bbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (head_item),
		.pop_valid (head_valid),
		.pop_ready (head_ready),
		.verdict   (verdict)
	);

endmodule

`default_nettype wire

[hdl/bbc_checker.sv]
// Port-level checker for the bracket balance checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bbc_checker
	import bbc_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       out_balanced,
	input wire logic [2:0] out_status
);

	// Strings whose last character was taken but whose verdict is not yet delivered.
	logic [3:0] pending_q;
	logic       last_in;
	logic       verdict_out;

	assign last_in     = in_valid && in_ready && in_last;
	assign verdict_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !verdict_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (verdict_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A verdict is only shown for a string that has ended.
	a_no_spurious_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("verdict shown with no ended string outstanding");

	// The balanced flag agrees with the status code.
	a_balanced_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_balanced == (out_status == ST_OK)))
		else $error("balanced flag disagrees with status");

	// Only defined status codes appear.
	a_status_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_OK || out_status == ST_MISMATCH ||
			out_status == ST_EMPTY || out_status == ST_UNCLOSED ||
			out_status == ST_OVERFLOW))
		else $error("undefined status code");

	// A stalled verdict stays up with its payload unchanged.
	a_verdict_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
			$stable(out_balanced)))
		else $error("stalled verdict changed or dropped");

endmodule

bind multi_bracket_balance_checker_unit bbc_checker u_bbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (chars.valid),
	.in_ready     (chars.ready),
	.in_last      (chars.last),
	.out_valid    (verdict.valid),
	.out_ready    (verdict.ready),
	.out_balanced (verdict.balanced),
	.out_status   (verdict.status)
);

`default_nettype wire
